@@ rtl/bvs_pkg.sv @@
// Shared constants and beat types for the bounded value set.
package bvs_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef logic [VALUE_WIDTH-1:0] elem_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic       found;
        logic [4:0] count;
        logic       empty_res;
        logic       dropped;
    } out_beat_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic  do_add;
        logic  do_remove;
        elem_t key;
    } cell_ctrl_t;

endpackage

@@ rtl/bvs_cell.sv @@
// One slot of the packed list: holds an element, matches the key, shifts down.
module bvs_cell
    import bvs_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       append_sel,
    input  logic       shift_in,
    input  elem_t      upper_data,
    output elem_t      data_out,
    output logic       shift_out
);

    elem_t data_reg;
    elem_t data_next;
    logic  hit;

    // Match only live slots
    assign hit       = occupied && (data_reg == ctrl.key);
    assign shift_out = shift_in || hit;
    assign data_out  = data_reg;

    // Take the neighbor's element on a remove at or below this slot, or the key on append
    always_comb begin
        data_next = data_reg;
        if (ctrl.do_remove && shift_out) begin
            data_next = upper_data;
        end else if (ctrl.do_add && append_sel) begin
            data_next = ctrl.key;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/bounded_value_set.sv @@
// Top level of the bounded value set: cell row, fill count and result register.
//
// Bounded value set: holds up to CAPACITY distinct signed values in a row of
// cells, packed from slot 0. Each input beat is an add, a remove or a query
// (code 3 acts as a query); each yields one result beat with found (value was
// present before the operation), the new count, an empty flag and dropped (an
// add of an absent value into a full set). For every beat, all
// cells compare the key in parallel and a remove shifts the upper cells down
// one slot in the same cycle. A new beat is taken every cycle as long as the
// result register is empty or being drained. Results are registered and
// appear in the cycle after acceptance. Stored values reset to undefined;
// only slots below the count are ever matched.
module bounded_value_set
    import bvs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    out_beat_t          m_payload_reg;
    out_beat_t          m_payload_next;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               found;
    logic               full;
    logic               is_add;
    logic               is_remove;
    logic               dropped;
    logic [CAPACITY:0]  shift_chain;
    elem_t              cell_data [CAPACITY];
    elem_t              upper_data [CAPACITY];

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_add    = (s_payload.operation == OP_ADD);
    assign is_remove = (s_payload.operation == OP_REMOVE);
    assign full      = (count_reg == COUNT_W'(CAPACITY));

    // Broadcast the key and the operation to the cells
    assign ctrl.key       = VALUE_WIDTH'(s_payload.value);
    assign ctrl.do_add    = accept && is_add && !found && !full;
    assign ctrl.do_remove = accept && is_remove;

    assign shift_chain[0] = 1'b0;
    assign found          = shift_chain[CAPACITY];
    assign dropped        = is_add && !found && full;

    // Build the row of cells, each fed by its upper neighbor or, at the top, by the key
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == CAPACITY - 1) begin : g_top
            assign upper_data[i] = ctrl.key;
        end else begin : g_mid
            assign upper_data[i] = cell_data[i+1];
        end

        bvs_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (COUNT_W'(i) < count_reg),
            .append_sel (COUNT_W'(i) == count_reg),
            .shift_in   (shift_chain[i]),
            .upper_data (upper_data[i]),
            .data_out   (cell_data[i]),
            .shift_out  (shift_chain[i+1])
        );
    end

    // Advance the count and load the result register
    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            if (ctrl.do_add) begin
                count_next = count_reg + COUNT_W'(1);
            end else if (is_remove && found) begin
                count_next = count_reg - COUNT_W'(1);
            end
            m_valid_next             = 1'b1;
            m_payload_next.found     = found;
            m_payload_next.count     = 5'(count_next);
            m_payload_next.empty_res = (count_next == '0);
            m_payload_next.dropped   = dropped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_remove && found |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("remove of present value did not decrement count");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_payload_reg.dropped |-> m_payload_reg.count == 5'(CAPACITY))
        else $error("dropped reported on a set that is not full");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_payload_reg.empty_res == (m_payload_reg.count == 5'd0))
        else $error("empty flag disagrees with count");

endmodule
